// ===== sv/gocm_pkg.sv =====
// Shared types, widths and codes for the grow-only counter merge block.
// Used by gocm_apb, gocm_ctrl, gocm_dp and grow_only_counter_merge.
// No dependencies.
package gocm_pkg;

    // Built number of replica components.
    localparam int MAX_REPLICAS = 8;
    localparam int IDX_W = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
    localparam int CNT_W = $clog2(MAX_REPLICAS + 1);

    // Fixed field widths.
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int KIND_W   = 3;
    localparam int IDXRES_W = 6;
    localparam int REL_W    = 2;
    localparam int ERR_W    = 2;
    localparam int ACT_W    = 7;
    localparam int LOC_W    = 6;
    localparam int POS_W    = 7;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [POS_W-1:0] POS_MAX      = 7'd127;
    localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd8;
    localparam logic [LOC_W-1:0] LOCAL_RESET  = 6'd0;

    // Register index, taken from paddr[2].
    localparam logic REG_ACTIVE = 1'b0;
    localparam logic REG_LOCAL  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INC  = 2'd0,
        CMD_SUM  = 2'd1,
        CMD_UPD  = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_INC   = 3'd0,
        KIND_NEWER = 3'd1,
        KIND_REL   = 3'd2,
        KIND_ELEM  = 3'd3,
        KIND_MERGE = 3'd4
    } t_kind;

    typedef enum logic [REL_W-1:0] {
        REL_EQUIV  = 2'd0,
        REL_LOCAL  = 2'd1,
        REL_REMOTE = 2'd2,
        REL_INCOMP = 2'd3
    } t_rel;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_COUNT = 2'd1,
        ERR_INDEX = 2'd2
    } t_err;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_INC,
        ST_SUM,
        ST_REL,
        ST_UPD,
        ST_MRG_RD,
        ST_MRG_WR,
        ST_MRG_OUT,
        ST_RD_FETCH,
        ST_RD_OUT
    } t_state;

    typedef enum logic [1:0] {
        ADDR_LOCAL,
        ADDR_POS,
        ADDR_INDEX,
        ADDR_COUNT
    } t_addr_sel;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INC,
        OP_SUM,
        OP_REL,
        OP_UPD,
        OP_MERGE,
        OP_MERGE_OUT,
        OP_READ_OUT
    } t_dp_op;

    typedef struct packed {
        logic      capture;
        t_addr_sel addr_sel;
        t_dp_op    op;
        logic      cnt_inc;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic last;
        logic upd_bad;
        logic cnt_merge_end;
        logic cnt_read_end;
        logic slot_free;
    } t_dp_stat;

    // Number of components in use, clamped to 1..MAX_REPLICAS.
    function automatic logic [CNT_W-1:0] active_count(input logic [ACT_W-1:0] a);
        logic [CNT_W-1:0] n;
        if (a == '0) begin
            n = CNT_W'(1);
        end else if (a > ACT_W'(MAX_REPLICAS)) begin
            n = CNT_W'(MAX_REPLICAS);
        end else begin
            n = a[CNT_W-1:0];
        end
        return n;
    endfunction

endpackage

// ===== sv/grow_only_counter_merge.sv =====
// Grow-only counter merge engine, top level.
// Depends on gocm_pkg, gocm_apb, gocm_ctrl and gocm_dp.
//
// The block takes one item at a time: an item is accepted only while the controller is
// idle, and results go out through a one-entry output register, so a new item can be
// taken while the last result still waits. Each item passes through the transfer, a read of
// the component array (single address, registered read) and an execute step. A summary
// element that ends a summary adds a step for the relation result. A final update entry
// adds a merge sweep over every built component (read, then compare and write) and then
// the merge result; an update that named an unknown index skips the sweep and goes
// straight to the merge result. A summary read takes the transfer, a fetch step, and then
// a read and an output step for each component in use. Stalls on the output side hold
// every step that can give a result; the update step and the merge sweep do not wait.
module grow_only_counter_merge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gocm_pkg::APB_AW-1:0]     paddr,
    input  logic [gocm_pkg::APB_DW-1:0]     pwdata,
    output logic [gocm_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [gocm_pkg::CMD_W-1:0]      i_cmd,
    input  logic [gocm_pkg::INDEX_W-1:0]    i_index,
    input  logic [gocm_pkg::VALUE_W-1:0]    i_value,
    input  logic                            i_last,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [gocm_pkg::KIND_W-1:0]     o_kind,
    output logic [gocm_pkg::IDXRES_W-1:0]   o_index_res,
    output logic [gocm_pkg::VALUE_W-1:0]    o_value_res,
    output logic [gocm_pkg::REL_W-1:0]      o_relation,
    output logic                            o_changed,
    output logic [gocm_pkg::ERR_W-1:0]      o_error,
    output logic                            o_last_res,
    output logic [gocm_pkg::VALUE_W-1:0]    o_total
);

    logic [gocm_pkg::ACT_W-1:0] active_replicas;
    logic [gocm_pkg::LOC_W-1:0] inc_slot;
    gocm_pkg::t_dp_cmd          dp_cmd;
    gocm_pkg::t_dp_stat         dp_stat;

    gocm_apb u_apb (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_active_replicas (active_replicas),
        .o_inc_slot        (inc_slot)
    );

    gocm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_dp_stat  (dp_stat),
        .o_dp_cmd   (dp_cmd)
    );

    gocm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_dp_cmd          (dp_cmd),
        .o_dp_stat         (dp_stat),
        .i_active_replicas (active_replicas),
        .i_inc_slot        (inc_slot),
        .i_cmd             (i_cmd),
        .i_index           (i_index),
        .i_value           (i_value),
        .i_last            (i_last),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_index_res       (o_index_res),
        .o_value_res       (o_value_res),
        .o_relation        (o_relation),
        .o_changed         (o_changed),
        .o_error           (o_error),
        .o_last_res        (o_last_res),
        .o_total           (o_total)
    );

endmodule

// ===== sv/gocm_apb.sv =====
// Configuration registers of the grow-only counter merge block on an APB-style port.
// Depends on gocm_pkg.
module gocm_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gocm_pkg::APB_AW-1:0]   paddr,
    input  logic [gocm_pkg::APB_DW-1:0]   pwdata,
    output logic [gocm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [gocm_pkg::ACT_W-1:0]    o_active_replicas,
    output logic [gocm_pkg::LOC_W-1:0]    o_inc_slot
);

    logic [gocm_pkg::ACT_W-1:0] r_active;
    logic [gocm_pkg::LOC_W-1:0] r_local;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= gocm_pkg::ACTIVE_RESET;
            r_local  <= gocm_pkg::LOCAL_RESET;
        end else if (wr_en) begin
            if (paddr[2] == gocm_pkg::REG_ACTIVE) begin
                r_active <= pwdata[gocm_pkg::ACT_W-1:0];
            end else begin
                r_local <= pwdata[gocm_pkg::LOC_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == gocm_pkg::REG_LOCAL) begin
            prdata = gocm_pkg::APB_DW'(r_local);
        end else begin
            prdata = gocm_pkg::APB_DW'(r_active);
        end
    end

    assign o_active_replicas = r_active;
    assign o_inc_slot        = r_local;

endmodule

// ===== sv/gocm_dp.sv =====
// Datapath of the grow-only counter merge block: component and pending arrays,
// summary and update tracking, running total and the output register. Depends on gocm_pkg.
module gocm_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gocm_pkg::t_dp_cmd               i_dp_cmd,
    output gocm_pkg::t_dp_stat              o_dp_stat,
    input  logic [gocm_pkg::ACT_W-1:0]      i_active_replicas,
    input  logic [gocm_pkg::LOC_W-1:0]      i_inc_slot,
    input  logic [gocm_pkg::CMD_W-1:0]      i_cmd,
    input  logic [gocm_pkg::INDEX_W-1:0]    i_index,
    input  logic [gocm_pkg::VALUE_W-1:0]    i_value,
    input  logic                            i_last,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [gocm_pkg::KIND_W-1:0]     o_kind,
    output logic [gocm_pkg::IDXRES_W-1:0]   o_index_res,
    output logic [gocm_pkg::VALUE_W-1:0]    o_value_res,
    output logic [gocm_pkg::REL_W-1:0]      o_relation,
    output logic                            o_changed,
    output logic [gocm_pkg::ERR_W-1:0]      o_error,
    output logic                            o_last_res,
    output logic [gocm_pkg::VALUE_W-1:0]    o_total
);

    localparam int MR = gocm_pkg::MAX_REPLICAS;
    localparam int AW = gocm_pkg::IDX_W;
    localparam int VW = gocm_pkg::VALUE_W;

    // Captured input item.
    gocm_pkg::t_cmd                 r_cmd;
    logic [gocm_pkg::INDEX_W-1:0]   r_idx;
    logic [VW-1:0]                  r_val;
    logic                           r_last;

    // Component and pending arrays, single address per cycle, registered read.
    logic [VW-1:0]   r_comp [MR];
    logic [MR-1:0]   r_comp_vld;
    logic [VW-1:0]   r_pend [MR];
    logic [MR-1:0]   r_pend_vld;
    logic [VW-1:0]   r_comp_rd;
    logic [VW-1:0]   r_pend_rd;

    logic [VW-1:0]                  r_total;
    logic [VW-1:0]                  n_total;
    logic [gocm_pkg::POS_W-1:0]     r_pos;
    logic                           r_sum_bad;
    logic                           r_local_gt;
    logic                           r_remote_gt;
    logic                           r_update_bad;
    logic                           r_changed;
    logic [AW-1:0]                  r_cnt;

    // Output register.
    logic                   r_out_valid;
    gocm_pkg::t_kind        r_kind,    n_kind;
    logic [gocm_pkg::IDXRES_W-1:0] r_index_res, n_index_res;
    logic [VW-1:0]          r_value_res, n_value_res;
    gocm_pkg::t_rel         r_rel,     n_rel;
    logic                   r_chg,     n_chg;
    gocm_pkg::t_err         r_err,     n_err;
    logic                   r_lst,     n_lst;
    logic [VW-1:0]          r_tot_out;
    logic                   emit;

    logic [gocm_pkg::CNT_W-1:0] n_act;
    logic [AW-1:0]   addr;
    logic            local_ok;
    logic            pos_ok;
    logic            idx_ok;
    logic            gt;
    logic            lt;
    logic            raise;
    logic            pend_we;
    logic            comp_we;
    logic [VW-1:0]   comp_wd;
    logic            rel_bad;

    assign n_act    = gocm_pkg::active_count(i_active_replicas);
    assign local_ok = gocm_pkg::INDEX_W'(i_inc_slot) < gocm_pkg::INDEX_W'(n_act);
    assign pos_ok   = gocm_pkg::INDEX_W'(r_pos) < gocm_pkg::INDEX_W'(n_act);
    assign idx_ok   = r_idx < gocm_pkg::INDEX_W'(n_act);
    assign gt       = pos_ok && (r_comp_rd > r_val);
    assign lt       = pos_ok && (r_comp_rd < r_val);
    assign raise    = r_pend_vld[addr] && (r_pend_rd > r_comp_rd);
    assign rel_bad  = r_sum_bad || (r_pos != gocm_pkg::POS_W'(n_act));

    always_comb begin
        case (i_dp_cmd.addr_sel)
            gocm_pkg::ADDR_LOCAL: addr = i_inc_slot[AW-1:0];
            gocm_pkg::ADDR_POS:   addr = r_pos[AW-1:0];
            gocm_pkg::ADDR_INDEX: addr = r_idx[AW-1:0];
            default:              addr = r_cnt;
        endcase
    end

    // Array write controls.
    always_comb begin
        comp_we = 1'b0;
        comp_wd = r_pend_rd;
        pend_we = 1'b0;
        n_total = r_total;
        case (i_dp_cmd.op)
            gocm_pkg::OP_INC: begin
                if (local_ok) begin
                    comp_we = 1'b1;
                    comp_wd = r_comp_rd + VW'(1);
                    n_total = r_total + VW'(1);
                end
            end
            gocm_pkg::OP_UPD: begin
                pend_we = idx_ok && (!r_pend_vld[addr] || (r_val > r_pend_rd));
            end
            gocm_pkg::OP_MERGE: begin
                if (raise) begin
                    comp_we = 1'b1;
                    n_total = r_total + r_pend_rd - r_comp_rd;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (comp_we) begin
            r_comp[addr] <= comp_wd;
        end
        if (pend_we) begin
            r_pend[addr] <= r_val;
        end
        // A component entry never written since reset reads as zero.
        r_comp_rd <= r_comp_vld[addr] ? r_comp[addr] : '0;
        r_pend_rd <= r_pend[addr];
        if (i_dp_cmd.capture) begin
            r_cmd  <= gocm_pkg::t_cmd'(i_cmd);
            r_idx  <= i_index;
            r_val  <= i_value;
            r_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp_vld   <= '0;
            r_pend_vld   <= '0;
            r_total      <= '0;
            r_pos        <= '0;
            r_sum_bad    <= 1'b0;
            r_local_gt   <= 1'b0;
            r_remote_gt  <= 1'b0;
            r_update_bad <= 1'b0;
            r_changed    <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_total <= n_total;
            if (comp_we) begin
                r_comp_vld[addr] <= 1'b1;
            end
            if (i_dp_cmd.capture) begin
                r_cnt <= '0;
            end else if (i_dp_cmd.cnt_inc) begin
                r_cnt <= r_cnt + AW'(1);
            end
            case (i_dp_cmd.op)
                gocm_pkg::OP_SUM: begin
                    r_local_gt  <= r_local_gt | gt;
                    r_remote_gt <= r_remote_gt | lt;
                    r_sum_bad   <= r_sum_bad | !pos_ok;
                    if (r_pos != gocm_pkg::POS_MAX) begin
                        r_pos <= r_pos + gocm_pkg::POS_W'(1);
                    end
                end
                gocm_pkg::OP_REL: begin
                    r_pos       <= '0;
                    r_sum_bad   <= 1'b0;
                    r_local_gt  <= 1'b0;
                    r_remote_gt <= 1'b0;
                end
                gocm_pkg::OP_UPD: begin
                    if (idx_ok) begin
                        r_pend_vld[addr] <= 1'b1;
                    end else begin
                        r_update_bad <= 1'b1;
                    end
                end
                gocm_pkg::OP_MERGE: begin
                    if (raise) begin
                        r_changed <= 1'b1;
                    end
                end
                gocm_pkg::OP_MERGE_OUT: begin
                    r_pend_vld   <= '0;
                    r_update_bad <= 1'b0;
                    r_changed    <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Result selection for the output register.
    always_comb begin
        emit        = 1'b0;
        n_kind      = gocm_pkg::KIND_INC;
        n_index_res = '0;
        n_value_res = '0;
        n_rel       = gocm_pkg::REL_EQUIV;
        n_chg       = 1'b0;
        n_err       = gocm_pkg::ERR_NONE;
        n_lst       = 1'b1;
        case (i_dp_cmd.op)
            gocm_pkg::OP_INC: begin
                emit = 1'b1;
                if (!local_ok) begin
                    n_err = gocm_pkg::ERR_INDEX;
                end
            end
            gocm_pkg::OP_SUM: begin
                emit        = gt;
                n_kind      = gocm_pkg::KIND_NEWER;
                n_index_res = gocm_pkg::IDXRES_W'(r_pos);
                n_value_res = r_comp_rd;
                n_lst       = 1'b0;
            end
            gocm_pkg::OP_REL: begin
                emit   = 1'b1;
                n_kind = gocm_pkg::KIND_REL;
                if (rel_bad) begin
                    n_err = gocm_pkg::ERR_COUNT;
                end else if (r_local_gt && r_remote_gt) begin
                    n_rel = gocm_pkg::REL_INCOMP;
                end else if (r_remote_gt) begin
                    n_rel = gocm_pkg::REL_REMOTE;
                end else if (r_local_gt) begin
                    n_rel = gocm_pkg::REL_LOCAL;
                end
            end
            gocm_pkg::OP_MERGE_OUT: begin
                emit   = 1'b1;
                n_kind = gocm_pkg::KIND_MERGE;
                n_chg  = r_changed;
                if (r_update_bad) begin
                    n_err = gocm_pkg::ERR_INDEX;
                end
            end
            gocm_pkg::OP_READ_OUT: begin
                emit        = 1'b1;
                n_kind      = gocm_pkg::KIND_ELEM;
                n_index_res = gocm_pkg::IDXRES_W'(r_cnt);
                n_value_res = r_comp_rd;
                n_lst       = o_dp_stat.cnt_read_end;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind      <= n_kind;
            r_index_res <= n_index_res;
            r_value_res <= n_value_res;
            r_rel       <= n_rel;
            r_chg       <= n_chg;
            r_err       <= n_err;
            r_lst       <= n_lst;
            r_tot_out   <= n_total;
        end
    end

    assign o_dp_stat.cmd           = r_cmd;
    assign o_dp_stat.last          = r_last;
    assign o_dp_stat.upd_bad       = r_update_bad | !idx_ok;
    assign o_dp_stat.cnt_merge_end = (r_cnt == AW'(MR - 1));
    assign o_dp_stat.cnt_read_end  =
        ((gocm_pkg::CNT_W'(r_cnt) + gocm_pkg::CNT_W'(1)) == n_act);
    assign o_dp_stat.slot_free     = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_index_res = r_index_res;
    assign o_value_res = r_value_res;
    assign o_relation  = r_rel;
    assign o_changed   = r_chg;
    assign o_error     = r_err;
    assign o_last_res  = r_lst;
    assign o_total     = r_tot_out;

endmodule

// ===== sv/gocm_ctrl.sv =====
// Controller state machine of the grow-only counter merge block.
// Sequences the datapath through fetch, execute, merge and readout. Depends on gocm_pkg.
module gocm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gocm_pkg::t_dp_stat   i_dp_stat,
    output gocm_pkg::t_dp_cmd    o_dp_cmd
);

    gocm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gocm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gocm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = gocm_pkg::ST_FETCH;
                end
            end
            gocm_pkg::ST_FETCH: begin
                case (i_dp_stat.cmd)
                    gocm_pkg::CMD_INC: n_state = gocm_pkg::ST_INC;
                    gocm_pkg::CMD_SUM: n_state = gocm_pkg::ST_SUM;
                    gocm_pkg::CMD_UPD: n_state = gocm_pkg::ST_UPD;
                    default:           n_state = gocm_pkg::ST_RD_FETCH;
                endcase
            end
            gocm_pkg::ST_INC: begin
                if (i_dp_stat.slot_free) begin
                    n_state = gocm_pkg::ST_IDLE;
                end
            end
            gocm_pkg::ST_SUM: begin
                if (i_dp_stat.slot_free) begin
                    n_state = i_dp_stat.last ? gocm_pkg::ST_REL : gocm_pkg::ST_IDLE;
                end
            end
            gocm_pkg::ST_REL: begin
                if (i_dp_stat.slot_free) begin
                    n_state = gocm_pkg::ST_IDLE;
                end
            end
            gocm_pkg::ST_UPD: begin
                if (!i_dp_stat.last) begin
                    n_state = gocm_pkg::ST_IDLE;
                end else if (i_dp_stat.upd_bad) begin
                    n_state = gocm_pkg::ST_MRG_OUT;
                end else begin
                    n_state = gocm_pkg::ST_MRG_RD;
                end
            end
            gocm_pkg::ST_MRG_RD: n_state = gocm_pkg::ST_MRG_WR;
            gocm_pkg::ST_MRG_WR: begin
                n_state = i_dp_stat.cnt_merge_end ? gocm_pkg::ST_MRG_OUT
                                                  : gocm_pkg::ST_MRG_RD;
            end
            gocm_pkg::ST_MRG_OUT: begin
                if (i_dp_stat.slot_free) begin
                    n_state = gocm_pkg::ST_IDLE;
                end
            end
            gocm_pkg::ST_RD_FETCH: n_state = gocm_pkg::ST_RD_OUT;
            gocm_pkg::ST_RD_OUT: begin
                if (i_dp_stat.slot_free) begin
                    n_state = i_dp_stat.cnt_read_end ? gocm_pkg::ST_IDLE
                                                     : gocm_pkg::ST_RD_FETCH;
                end
            end
            default: n_state = gocm_pkg::ST_IDLE;
        endcase
    end

    // Outputs. The address source stays fixed from fetch through execute.
    always_comb begin
        o_in_ready        = 1'b0;
        o_dp_cmd.capture  = 1'b0;
        o_dp_cmd.addr_sel = gocm_pkg::ADDR_COUNT;
        o_dp_cmd.op       = gocm_pkg::OP_NONE;
        o_dp_cmd.cnt_inc  = 1'b0;
        case (r_state)
            gocm_pkg::ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_dp_cmd.capture = i_in_valid;
            end
            gocm_pkg::ST_FETCH: begin
                case (i_dp_stat.cmd)
                    gocm_pkg::CMD_INC: o_dp_cmd.addr_sel = gocm_pkg::ADDR_LOCAL;
                    gocm_pkg::CMD_SUM: o_dp_cmd.addr_sel = gocm_pkg::ADDR_POS;
                    gocm_pkg::CMD_UPD: o_dp_cmd.addr_sel = gocm_pkg::ADDR_INDEX;
                    default:           o_dp_cmd.addr_sel = gocm_pkg::ADDR_COUNT;
                endcase
            end
            gocm_pkg::ST_INC: begin
                o_dp_cmd.addr_sel = gocm_pkg::ADDR_LOCAL;
                if (i_dp_stat.slot_free) begin
                    o_dp_cmd.op = gocm_pkg::OP_INC;
                end
            end
            gocm_pkg::ST_SUM: begin
                o_dp_cmd.addr_sel = gocm_pkg::ADDR_POS;
                if (i_dp_stat.slot_free) begin
                    o_dp_cmd.op = gocm_pkg::OP_SUM;
                end
            end
            gocm_pkg::ST_REL: begin
                if (i_dp_stat.slot_free) begin
                    o_dp_cmd.op = gocm_pkg::OP_REL;
                end
            end
            gocm_pkg::ST_UPD: begin
                o_dp_cmd.addr_sel = gocm_pkg::ADDR_INDEX;
                o_dp_cmd.op       = gocm_pkg::OP_UPD;
            end
            gocm_pkg::ST_MRG_WR: begin
                o_dp_cmd.op      = gocm_pkg::OP_MERGE;
                o_dp_cmd.cnt_inc = !i_dp_stat.cnt_merge_end;
            end
            gocm_pkg::ST_MRG_OUT: begin
                if (i_dp_stat.slot_free) begin
                    o_dp_cmd.op = gocm_pkg::OP_MERGE_OUT;
                end
            end
            gocm_pkg::ST_RD_OUT: begin
                if (i_dp_stat.slot_free) begin
                    o_dp_cmd.op      = gocm_pkg::OP_READ_OUT;
                    o_dp_cmd.cnt_inc = !i_dp_stat.cnt_read_end;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== tb/grow_only_counter_merge_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for grow_only_counter_merge: a directed table, then random
// runs over several register settings, checked against a behavioral counter model.
// Depends on gocm_pkg and the grow_only_counter_merge RTL.
module grow_only_counter_merge_test;

    localparam int SETTLE_CYCLES = 4 * gocm_pkg::MAX_REPLICAS + 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DIR_ROWS      = 20;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 15;
    localparam int LONG_SUMMARY  = 130;
    localparam int PRINT_CAP     = 100;

    typedef enum int {LEAN_EQUAL, LEAN_UP, LEAN_DOWN, LEAN_MIXED} t_lean;

    typedef struct packed {
        gocm_pkg::t_kind kind;
        logic [5:0]      index_res;
        logic [31:0]     value_res;
        gocm_pkg::t_rel  relation;
        logic            changed;
        gocm_pkg::t_err  error;
        logic            last_res;
        logic [31:0]     total;
    } t_result;

    typedef struct packed {
        gocm_pkg::t_cmd  cmd;
        logic [7:0]      index;
        logic [31:0]     value;
        logic            last;
        logic            typed;
        gocm_pkg::t_kind kind;
        gocm_pkg::t_rel  rel;
        gocm_pkg::t_err  err;
        logic [31:0]     total;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_cmd = '0;
    logic [7:0]  i_index = '0;
    logic [31:0] i_value = '0;
    logic        i_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [5:0]  o_index_res;
    logic [31:0] o_value_res;
    logic [1:0]  o_relation;
    logic        o_changed;
    logic [1:0]  o_error;
    logic        o_last_res;
    logic [31:0] o_total;

    grow_only_counter_merge u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_index_res (o_index_res),
        .o_value_res (o_value_res),
        .o_relation  (o_relation),
        .o_changed   (o_changed),
        .o_error     (o_error),
        .o_last_res  (o_last_res),
        .o_total     (o_total)
    );

    always #1 i_clk = ~i_clk;

    // Shadow of the counter: registers, components and the in-flight summary and update.
    logic [6:0]  cfg_active = gocm_pkg::ACTIVE_RESET;
    logic [5:0]  cfg_local  = gocm_pkg::LOCAL_RESET;
    logic [31:0] comps [gocm_pkg::MAX_REPLICAS];
    logic [31:0] running_total = '0;
    logic [31:0] pend_val [gocm_pkg::MAX_REPLICAS];
    logic [gocm_pkg::MAX_REPLICAS-1:0] pend_valid = '0;
    logic        upd_bad = 1'b0;
    logic [6:0]  sum_pos = '0;
    logic        sum_bad = 1'b0;
    logic        loc_gt = 1'b0;
    logic        rem_gt = 1'b0;

    t_result results_due [$];
    int      fail_count = 0;
    int      results_seen = 0;
    int      items_sent = 0;
    int      quiet_cycles = 0;
    logic    calm = 1'b0;

    t_stim_row dir_rows [DIR_ROWS] = '{
        '{gocm_pkg::CMD_INC,  8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd1},
        '{gocm_pkg::CMD_READ, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_SUM,  8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1,
          gocm_pkg::KIND_REL,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_COUNT, 32'd1},
        '{gocm_pkg::CMD_UPD,  8'hFF, 32'h0000_0000, 1'b1, 1'b1,
          gocm_pkg::KIND_MERGE, gocm_pkg::REL_EQUIV, gocm_pkg::ERR_INDEX, 32'd1},
        '{gocm_pkg::CMD_UPD,  8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_UPD,  8'h07, 32'd5,         1'b0, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_UPD,  8'h07, 32'd3,         1'b0, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_UPD,  8'h03, 32'd0,         1'b1, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_INC,  8'h00, 32'd0,         1'b0, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_SUM,  8'h00, 32'd0,         1'b0, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_SUM,  8'hFF, 32'd1,         1'b0, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_SUM,  8'h00, 32'd0,         1'b0, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_SUM,  8'h00, 32'd0,         1'b0, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_SUM,  8'h00, 32'd0,         1'b0, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_SUM,  8'h00, 32'd0,         1'b0, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_SUM,  8'h00, 32'd0,         1'b0, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_SUM,  8'h00, 32'd2,         1'b1, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_UPD,  8'h08, 32'd9,         1'b0, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0},
        '{gocm_pkg::CMD_UPD,  8'h01, 32'd9,         1'b1, 1'b1,
          gocm_pkg::KIND_MERGE, gocm_pkg::REL_EQUIV, gocm_pkg::ERR_INDEX, 32'd5},
        '{gocm_pkg::CMD_READ, 8'h00, 32'd0,         1'b0, 1'b0,
          gocm_pkg::KIND_INC,   gocm_pkg::REL_EQUIV, gocm_pkg::ERR_NONE,  32'd0}
    };

    int unsigned phase_active [PHASES] = '{1, 0, 127, 64, 3, 5, 8};
    int unsigned phase_local  [PHASES] = '{0, 0, 7, 63, 2, 6, 5};

    initial begin
        for (int i = 0; i < gocm_pkg::MAX_REPLICAS; i++) begin
            comps[i] = '0;
            pend_val[i] = '0;
        end
    end

    // Number of components in use, with out-of-range settings clamped.
    function automatic int unsigned used_count();
        if (cfg_active == 0) return 1;
        if (cfg_active > gocm_pkg::MAX_REPLICAS) return gocm_pkg::MAX_REPLICAS;
        return 32'(cfg_active);
    endfunction

    task automatic queue_result(input gocm_pkg::t_kind kind, input logic [5:0] idx,
                                input logic [31:0] val, input gocm_pkg::t_rel rel,
                                input logic chg, input gocm_pkg::t_err err,
                                input logic lst);
        t_result r;
        r = '{kind, idx, val, rel, chg, err, lst, running_total};
        results_due.insert(results_due.size(), r);
    endtask

    // Advances the shadow counter by one accepted item and queues the results it causes.
    task automatic counter_step(input gocm_pkg::t_cmd c, input logic [7:0] ix,
                                input logic [31:0] v, input logic l);
        int unsigned n;
        logic [31:0] here;
        logic        chg;
        n = used_count();
        case (c)
            gocm_pkg::CMD_INC: begin
                if (cfg_local < n) begin
                    comps[cfg_local] += 1;
                    running_total += 1;
                    queue_result(gocm_pkg::KIND_INC, '0, '0, gocm_pkg::REL_EQUIV, 1'b0,
                                 gocm_pkg::ERR_NONE, 1'b1);
                end else begin
                    queue_result(gocm_pkg::KIND_INC, '0, '0, gocm_pkg::REL_EQUIV, 1'b0,
                                 gocm_pkg::ERR_INDEX, 1'b1);
                end
            end
            gocm_pkg::CMD_SUM: begin
                if (sum_pos < n) begin
                    here = comps[sum_pos];
                    if (here > v) begin
                        loc_gt = 1'b1;
                        queue_result(gocm_pkg::KIND_NEWER, 6'(sum_pos), here,
                                     gocm_pkg::REL_EQUIV, 1'b0, gocm_pkg::ERR_NONE, 1'b0);
                    end else if (here < v) begin
                        rem_gt = 1'b1;
                    end
                end else begin
                    sum_bad = 1'b1;
                end
                if (sum_pos < gocm_pkg::POS_MAX) sum_pos++;
                if (l) begin
                    if (sum_bad || sum_pos != n)
                        queue_result(gocm_pkg::KIND_REL, '0, '0, gocm_pkg::REL_EQUIV, 1'b0,
                                     gocm_pkg::ERR_COUNT, 1'b1);
                    else
                        queue_result(gocm_pkg::KIND_REL, '0, '0,
                                     gocm_pkg::t_rel'({rem_gt, loc_gt}), 1'b0,
                                     gocm_pkg::ERR_NONE, 1'b1);
                    sum_pos = '0;
                    sum_bad = 1'b0;
                    loc_gt = 1'b0;
                    rem_gt = 1'b0;
                end
            end
            gocm_pkg::CMD_UPD: begin
                if (ix < n) begin
                    if (!pend_valid[ix] || v > pend_val[ix]) pend_val[ix] = v;
                    pend_valid[ix] = 1'b1;
                end else begin
                    upd_bad = 1'b1;
                end
                if (l) begin
                    chg = 1'b0;
                    if (upd_bad) begin
                        queue_result(gocm_pkg::KIND_MERGE, '0, '0, gocm_pkg::REL_EQUIV, 1'b0,
                                     gocm_pkg::ERR_INDEX, 1'b1);
                    end else begin
                        for (int i = 0; i < gocm_pkg::MAX_REPLICAS; i++) begin
                            if (pend_valid[i] && pend_val[i] > comps[i]) begin
                                running_total += pend_val[i] - comps[i];
                                comps[i] = pend_val[i];
                                chg = 1'b1;
                            end
                        end
                        queue_result(gocm_pkg::KIND_MERGE, '0, '0, gocm_pkg::REL_EQUIV, chg,
                                     gocm_pkg::ERR_NONE, 1'b1);
                    end
                    pend_valid = '0;
                    upd_bad = 1'b0;
                end
            end
            default: begin
                for (int unsigned i = 0; i < n; i++)
                    queue_result(gocm_pkg::KIND_ELEM, 6'(i), comps[i], gocm_pkg::REL_EQUIV,
                                 1'b0, gocm_pkg::ERR_NONE, i + 1 == n);
            end
        endcase
    endtask

    // A value near the stored component (a random base past the built ones), leaning the way the caller wants.
    function automatic logic [31:0] near_value(input int unsigned pos, input t_lean lean);
        logic [31:0] base;
        int unsigned pick;
        base = (pos < gocm_pkg::MAX_REPLICAS) ? comps[pos] : $urandom;
        pick = $urandom_range(9);
        case (lean)
            LEAN_EQUAL: return base;
            LEAN_UP:    return (pick < 4) ? base : base + $urandom_range(1, 3);
            LEAN_DOWN:  return (pick < 4) ? base : base - $urandom_range(1, 3);
            default: begin
                if (pick < 5) return base;
                if (pick < 7) return base + $urandom_range(1, 3);
                if (pick < 9) return base - $urandom_range(1, 3);
                return $urandom;
            end
        endcase
    endfunction

    // Presents one item, holds it until the transfer, then updates the shadow counter.
    task automatic send_item(input gocm_pkg::t_cmd c, input logic [7:0] ix,
                             input logic [31:0] v, input logic l);
        while (!calm && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= c;
        i_index    <= ix;
        i_value    <= v;
        i_last     <= l;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        counter_step(c, ix, v, l);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic sel_reg, input logic [6:0] data);
        logic [31:0] word;
        word = $urandom;
        if (sel_reg == gocm_pkg::REG_ACTIVE) word[6:0] = data;
        else word[5:0] = data[5:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel_reg, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel_reg == gocm_pkg::REG_ACTIVE) cfg_active = word[6:0];
        else cfg_local = word[5:0];
        @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_CAP)
            $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
        fail_count++;
    endtask

    // Receiver: random back-pressure, except during calm stretches.
    always @(posedge i_clk) i_out_ready <= calm || ($urandom_range(99) >= 29);

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected transfer, kind", 32'(o_kind), '0);
            end else begin
                want = results_due.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch("kind", 32'(o_kind), 32'(want.kind));
                if (o_index_res !== want.index_res)
                    report_mismatch("index_res", 32'(o_index_res), 32'(want.index_res));
                if (o_value_res !== want.value_res)
                    report_mismatch("value_res", o_value_res, want.value_res);
                if (o_relation !== want.relation)
                    report_mismatch("relation", 32'(o_relation), 32'(want.relation));
                if (o_changed !== want.changed)
                    report_mismatch("changed", 32'(o_changed), 32'(want.changed));
                if (o_error !== want.error)
                    report_mismatch("error", 32'(o_error), 32'(want.error));
                if (o_last_res !== want.last_res)
                    report_mismatch("last_res", 32'(o_last_res), 32'(want.last_res));
                if (o_total !== want.total) report_mismatch("total", o_total, want.total);
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("FAIL grow_only_counter_merge");
        $finish;
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned len;
        int unsigned pick;
        int          start;
        logic [7:0]  ix;
        t_lean       lean;
        t_stim_row   row;
        t_result     typed;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            send_item(row.cmd, row.index, row.value, row.last);
            // Rows with a typed expectation cause exactly one result.
            if (row.typed) begin
                typed = '{row.kind, '0, '0, row.rel, 1'b0, row.err, 1'b1, row.total};
                void'(results_due.pop_back());
                results_due.insert(results_due.size(), typed);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            apb_write(gocm_pkg::REG_ACTIVE, 7'(phase_active[ph]));
            apb_write(gocm_pkg::REG_LOCAL, 7'(phase_local[ph]));
            calm = (ph == 4);
            n = used_count();

            // With one component in use, walk a summary far enough to saturate its position.
            if (n == 1 && ph == 0) begin
                for (int k = 0; k < LONG_SUMMARY; k++)
                    send_item(gocm_pkg::CMD_SUM, 8'($urandom), near_value(k, LEAN_MIXED),
                              k == LONG_SUMMARY - 1);
            end

            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 12) begin
                    send_item(gocm_pkg::CMD_INC, 8'($urandom), $urandom,
                              1'($urandom_range(1)));
                end else if (pick < 20) begin
                    send_item(gocm_pkg::CMD_READ, 8'($urandom), $urandom,
                              1'($urandom_range(1)));
                end else if (pick < 50) begin
                    len = ($urandom_range(9) < 7) ? n : $urandom_range(1, n + 3);
                    lean = t_lean'($urandom_range(3));
                    for (int unsigned k = 0; k < len; k++)
                        send_item(gocm_pkg::CMD_SUM, 8'($urandom), near_value(k, lean),
                                  k + 1 == len);
                end else if (pick < 82) begin
                    len = $urandom_range(1, n + 1);
                    for (int unsigned k = 0; k < len; k++) begin
                        if ($urandom_range(9) == 0) ix = 8'($urandom_range(n, 255));
                        else ix = 8'($urandom_range(n - 1));
                        send_item(gocm_pkg::CMD_UPD, ix,
                                  near_value(32'(ix),
                                             ($urandom_range(4) < 3) ? LEAN_UP : LEAN_MIXED),
                                  k + 1 == len);
                    end
                end else begin
                    send_item(gocm_pkg::t_cmd'($urandom_range(3)), 8'($urandom), $urandom,
                              1'($urandom_range(1)));
                end
                if ($urandom_range(99) < 5) drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && results_due.size() == 0) begin
            $display("PASS grow_only_counter_merge");
        end else begin
            $display("FAIL grow_only_counter_merge");
        end
        $finish;
    end

endmodule
